// ----- sv/lfpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lfpd_pkg: shared types and constants of the line follower PID drive
// Field widths, register reset values, register indexes and the
// transaction format passed from the front end to the back end.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int SENSORS_PER_GROUP  = 4;
  localparam int SAMPLE_BITS        = 12;
  localparam int GAIN_FRACTION_BITS = 16;

  localparam int GAIN_W   = 24;
  localparam int DRIVE_W  = 12;
  localparam int ILIM_W   = 20;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam int SUM_W   = SAMPLE_BITS + $clog2(SENSORS_PER_GROUP);
  localparam int ERR_W   = SUM_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int DERIV_W = DIFF_W + 7;          // times 100 stays below 2^7
  localparam int ACC_W   = ILIM_W + 1;
  localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W = GAIN_W + 1 + ACC_W;
  localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;
  localparam int PID_W   = PROD_D_W + 2;
  localparam int DUTY_W  = PID_W + 1;

  localparam logic [GAIN_W-1:0]      GAIN_P_RST   = GAIN_W'(18350);
  localparam logic [GAIN_W-1:0]      GAIN_I_RST   = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]      GAIN_D_RST   = GAIN_W'(393);
  localparam logic [DRIVE_W-1:0]     BASE_RST     = DRIVE_W'(700);
  localparam logic [ILIM_W-1:0]      ILIM_RST     = ILIM_W'(1000000);
  localparam logic [DRIVE_W-1:0]     DLIM_RST     = DRIVE_W'(2000);
  localparam logic [SAMPLE_BITS-1:0] MARK_HI_RST  = SAMPLE_BITS'(450);
  localparam logic [SAMPLE_BITS-1:0] MARK_LO_RST  = SAMPLE_BITS'(3800);

  localparam logic [1:0] HITS_TO_HALT = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_BASE      = 3'd3,
    REG_ILIM      = 3'd4,
    REG_DLIM      = 3'd5,
    REG_MARK_HI   = 3'd6,
    REG_MARK_LO   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]      gain_p;
    logic [GAIN_W-1:0]      gain_i;
    logic [GAIN_W-1:0]      gain_d;
    logic [DRIVE_W-1:0]     base_drive;
    logic [ILIM_W-1:0]      integral_limit;
    logic [DRIVE_W-1:0]     duty_limit;
    logic [SAMPLE_BITS-1:0] marker_high_threshold;
    logic [SAMPLE_BITS-1:0] marker_low_threshold;
  } cfg_t;

  typedef logic [SENSORS_PER_GROUP-1:0][SAMPLE_BITS-1:0] group_t;

  typedef struct packed {
    logic                     halt;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [ACC_W-1:0]  acc;
  } entry_t;

endpackage

// ----- sv/lfpd_front.sv -----
// ----------------------------------------------------------------------------
// lfpd_front: sensor front end
// Sums the sensor groups, counts marker hits and runs the error and
// accumulator recurrences for each accepted transaction.
// ----------------------------------------------------------------------------
module lfpd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  lfpd_pkg::cfg_t                      cfg,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  lfpd_pkg::group_t                    group_a,
  input  lfpd_pkg::group_t                    group_b,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]    marker_floor,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]    marker_mark,
  input  logic                                queue_full,
  output logic                                push,
  output lfpd_pkg::entry_t                    entry
);

  logic signed [lfpd_pkg::ERR_W-1:0]   last_error;
  logic signed [lfpd_pkg::ACC_W-1:0]   error_accumulator;
  logic [1:0]                          marker_hits;

  logic [lfpd_pkg::SUM_W-1:0]          sum_a;
  logic [lfpd_pkg::SUM_W-1:0]          sum_b;
  logic signed [lfpd_pkg::ERR_W-1:0]   err;
  logic signed [lfpd_pkg::ACC_W:0]     acc_raw;
  logic signed [lfpd_pkg::ACC_W:0]     acc_lim;
  logic signed [lfpd_pkg::ACC_W-1:0]   acc_next;
  logic                                hit;
  logic [1:0]                          marker_hits_next;
  logic                                halt;

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int i = 0; i < lfpd_pkg::SENSORS_PER_GROUP; i++) begin
      sum_a = sum_a + lfpd_pkg::SUM_W'(group_a[i]);
      sum_b = sum_b + lfpd_pkg::SUM_W'(group_b[i]);
    end
    err = $signed({1'b0, sum_b}) - $signed({1'b0, sum_a});

    hit = (marker_hits != lfpd_pkg::HITS_TO_HALT) &&
          (marker_mark > cfg.marker_high_threshold) &&
          (marker_floor < cfg.marker_low_threshold);
    marker_hits_next = marker_hits + {1'b0, hit};
    halt = (marker_hits_next == lfpd_pkg::HITS_TO_HALT);

    // clamp the accumulator to the symmetric integral limit
    acc_raw = (lfpd_pkg::ACC_W+1)'(error_accumulator) + (lfpd_pkg::ACC_W+1)'(err);
    acc_lim = $signed({2'b00, cfg.integral_limit});
    if (acc_raw > acc_lim) begin
      acc_next = lfpd_pkg::ACC_W'(acc_lim);
    end else if (acc_raw < -acc_lim) begin
      acc_next = lfpd_pkg::ACC_W'(-acc_lim);
    end else begin
      acc_next = lfpd_pkg::ACC_W'(acc_raw);
    end

    entry.halt = halt;
    entry.err  = err;
    entry.diff = lfpd_pkg::DIFF_W'(err) - lfpd_pkg::DIFF_W'(last_error);
    entry.acc  = acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error        <= '0;
      error_accumulator <= '0;
      marker_hits       <= '0;
    end else if (push) begin
      marker_hits <= marker_hits_next;
      // freeze the loop state once stopped
      if (!halt) begin
        last_error        <= err;
        error_accumulator <= acc_next;
      end
    end
  end

endmodule

// ----- sv/lfpd_queue.sv -----
// ----------------------------------------------------------------------------
// lfpd_queue: four-entry transaction queue
// Decouples the front end from the back end pipeline.
// ----------------------------------------------------------------------------
module lfpd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lfpd_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output lfpd_pkg::entry_t head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  lfpd_pkg::entry_t      slots [DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [PTR_W:0]        count;
  logic                  do_pop;

  assign full       = (count == (PTR_W+1)'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

// ----- sv/lfpd_back.sv -----
// ----------------------------------------------------------------------------
// lfpd_back: PID back end
// Derivative scaling, gain multiplies, sum, and wheel duty clamp and split,
// one stage each, ending in the result register.
// ----------------------------------------------------------------------------
module lfpd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  lfpd_pkg::cfg_t                    cfg,
  input  logic                              head_valid,
  input  lfpd_pkg::entry_t                  head,
  output logic                              pop,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              left_forward,
  output logic [lfpd_pkg::DRIVE_W-1:0]      left_duty,
  output logic                              right_forward,
  output logic [lfpd_pkg::DRIVE_W-1:0]      right_duty,
  output logic                              halted,
  output logic signed [lfpd_pkg::ERR_W-1:0] line_error
);

  localparam int FB = lfpd_pkg::GAIN_FRACTION_BITS;
  localparam int DW = lfpd_pkg::DUTY_W;

  logic advance;

  // stage 1: derivative term
  logic                                  s1_valid;
  logic                                  s1_halt;
  logic signed [lfpd_pkg::ERR_W-1:0]     s1_err;
  logic signed [lfpd_pkg::ACC_W-1:0]     s1_acc;
  logic signed [lfpd_pkg::DERIV_W-1:0]   s1_deriv;
  logic signed [lfpd_pkg::DERIV_W-1:0]   diff_ext;
  logic signed [lfpd_pkg::DERIV_W-1:0]   deriv_next;

  // stage 2: gain products
  logic                                  s2_valid;
  logic                                  s2_halt;
  logic signed [lfpd_pkg::ERR_W-1:0]     s2_err;
  logic signed [lfpd_pkg::PROD_P_W-1:0]  s2_prod_p;
  logic signed [lfpd_pkg::PROD_I_W-1:0]  s2_prod_i;
  logic signed [lfpd_pkg::PROD_D_W-1:0]  s2_prod_d;

  // stage 3: controller output
  logic                                  s3_valid;
  logic                                  s3_halt;
  logic signed [lfpd_pkg::ERR_W-1:0]     s3_err;
  logic signed [lfpd_pkg::PID_W-1:0]     s3_pid;

  logic signed [DW-1:0]                  base_fx;
  logic signed [DW-1:0]                  left_raw;
  logic signed [DW-1:0]                  right_raw;
  logic [lfpd_pkg::DRIVE_W:0]            left_drive;
  logic [lfpd_pkg::DRIVE_W:0]            right_drive;

  // clamp to the duty limit, return {direction, magnitude}
  function automatic logic [lfpd_pkg::DRIVE_W:0] drive_of(
    input logic signed [DW-1:0]              duty,
    input logic [lfpd_pkg::DRIVE_W-1:0]      limit
  );
    logic signed [DW-1:0] lim;
    logic signed [DW-1:0] clamped;
    logic signed [DW-1:0] mag;
    lim = $signed({{(DW-lfpd_pkg::DRIVE_W-FB){1'b0}}, limit, {FB{1'b0}}});
    if (duty > lim) begin
      clamped = lim;
    end else if (duty < -lim) begin
      clamped = -lim;
    end else begin
      clamped = duty;
    end
    mag = clamped[DW-1] ? -clamped : clamped;
    return {~clamped[DW-1], mag[FB+lfpd_pkg::DRIVE_W-1:FB]};
  endfunction

  assign advance = !result_valid || !result_stall;
  assign pop     = advance && head_valid;

  always_comb begin
    // times 100 as 64 + 32 + 4
    diff_ext   = lfpd_pkg::DERIV_W'(head.diff);
    deriv_next = (diff_ext <<< 6) + (diff_ext <<< 5) + (diff_ext <<< 2);

    base_fx   = $signed({{(DW-lfpd_pkg::DRIVE_W-FB){1'b0}}, cfg.base_drive, {FB{1'b0}}});
    left_raw  = DW'(s3_pid) - base_fx;
    right_raw = -DW'(s3_pid) - base_fx;
    left_drive  = drive_of(left_raw, cfg.duty_limit);
    right_drive = drive_of(right_raw, cfg.duty_limit);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_halt   <= head.halt;
      s1_err    <= head.err;
      s1_acc    <= head.acc;
      s1_deriv  <= deriv_next;

      s2_halt   <= s1_halt;
      s2_err    <= s1_err;
      s2_prod_p <= lfpd_pkg::PROD_P_W'($signed({1'b0, cfg.gain_p}))
                 * lfpd_pkg::PROD_P_W'(s1_err);
      s2_prod_i <= lfpd_pkg::PROD_I_W'($signed({1'b0, cfg.gain_i}))
                 * lfpd_pkg::PROD_I_W'(s1_acc);
      s2_prod_d <= lfpd_pkg::PROD_D_W'($signed({1'b0, cfg.gain_d}))
                 * lfpd_pkg::PROD_D_W'(s1_deriv);

      s3_halt   <= s2_halt;
      s3_err    <= s2_err;
      s3_pid    <= lfpd_pkg::PID_W'(s2_prod_p) + lfpd_pkg::PID_W'(s2_prod_i)
                 + lfpd_pkg::PID_W'(s2_prod_d);

      line_error <= s3_err;
      halted     <= s3_halt;
      // stopped: forward, zero duty on both wheels
      if (s3_halt) begin
        left_forward  <= 1'b1;
        left_duty     <= '0;
        right_forward <= 1'b1;
        right_duty    <= '0;
      end else begin
        left_forward  <= left_drive[lfpd_pkg::DRIVE_W];
        left_duty     <= left_drive[lfpd_pkg::DRIVE_W-1:0];
        right_forward <= right_drive[lfpd_pkg::DRIVE_W];
        right_duty    <= right_drive[lfpd_pkg::DRIVE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= head_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
    end
  end

endmodule

// ----- sv/line_follow_pid_drive_core.sv -----
// ----------------------------------------------------------------------------
// line_follow_pid_drive_core: line follower PID differential drive
// One transaction per control tick: eight line samples and two marker
// samples in, two wheel drive commands, a stop flag and the line error out.
// ----------------------------------------------------------------------------
// Input channel: item_valid / item_stall with the ten sample ports. Output
// channel: result_valid / result_stall with the drive fields. A transaction
// moves on a clock edge where valid is high and stall is low.
// The front end takes one transaction per cycle while item_stall is low, and
// sustains that rate while result_stall is low; a result passes through the
// queue slot and four back end stages (derivative, gain multiplies, sum, duty
// clamp into the result register). When result_stall is held, the back end
// pipeline holds as a whole and the four-entry queue keeps taking input until
// it fills; then item_stall rises. Registers are written through cfg_write /
// cfg_index / cfg_data, by the user only while the block is empty; the block
// does not enforce this. Synchronous reset restores the register defaults,
// clears the error history, accumulator and marker count, and empties the
// queue and pipeline. Two marker hits latch a stop until the next reset.
// ----------------------------------------------------------------------------
module line_follow_pid_drive_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [lfpd_pkg::CFG_W-1:0]               cfg_data,
  input  logic                                     item_valid,
  output logic                                     item_stall,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]         group_a_sample_0,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]         group_a_sample_1,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]         group_a_sample_2,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]         group_a_sample_3,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]         group_b_sample_0,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]         group_b_sample_1,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]         group_b_sample_2,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]         group_b_sample_3,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]         marker_floor_sample,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]         marker_mark_sample,
  output logic                                     result_valid,
  input  logic                                     result_stall,
  output logic                                     left_forward,
  output logic [lfpd_pkg::DRIVE_W-1:0]             left_duty,
  output logic                                     right_forward,
  output logic [lfpd_pkg::DRIVE_W-1:0]             right_duty,
  output logic                                     halted,
  output logic signed [lfpd_pkg::ERR_W-1:0]        line_error
);

  lfpd_pkg::cfg_t   cfg;
  lfpd_pkg::group_t group_a;
  lfpd_pkg::group_t group_b;
  lfpd_pkg::entry_t push_entry;
  lfpd_pkg::entry_t head;
  logic             push;
  logic             queue_full;
  logic             pop;
  logic             head_valid;

  assign group_a = {group_a_sample_3, group_a_sample_2, group_a_sample_1, group_a_sample_0};
  assign group_b = {group_b_sample_3, group_b_sample_2, group_b_sample_1, group_b_sample_0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p                <= lfpd_pkg::GAIN_P_RST;
      cfg.gain_i                <= lfpd_pkg::GAIN_I_RST;
      cfg.gain_d                <= lfpd_pkg::GAIN_D_RST;
      cfg.base_drive            <= lfpd_pkg::BASE_RST;
      cfg.integral_limit        <= lfpd_pkg::ILIM_RST;
      cfg.duty_limit            <= lfpd_pkg::DLIM_RST;
      cfg.marker_high_threshold <= lfpd_pkg::MARK_HI_RST;
      cfg.marker_low_threshold  <= lfpd_pkg::MARK_LO_RST;
    end else if (cfg_write) begin
      unique case (lfpd_pkg::reg_idx_t'(cfg_index))
        lfpd_pkg::REG_GAIN_P:  cfg.gain_p <= cfg_data;
        lfpd_pkg::REG_GAIN_I:  cfg.gain_i <= cfg_data;
        lfpd_pkg::REG_GAIN_D:  cfg.gain_d <= cfg_data;
        lfpd_pkg::REG_BASE:    cfg.base_drive <= cfg_data[lfpd_pkg::DRIVE_W-1:0];
        lfpd_pkg::REG_ILIM:    cfg.integral_limit <= cfg_data[lfpd_pkg::ILIM_W-1:0];
        lfpd_pkg::REG_DLIM:    cfg.duty_limit <= cfg_data[lfpd_pkg::DRIVE_W-1:0];
        lfpd_pkg::REG_MARK_HI: begin
          cfg.marker_high_threshold <= cfg_data[lfpd_pkg::SAMPLE_BITS-1:0];
        end
        lfpd_pkg::REG_MARK_LO: begin
          cfg.marker_low_threshold <= cfg_data[lfpd_pkg::SAMPLE_BITS-1:0];
        end
      endcase
    end
  end

  lfpd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .group_a      (group_a),
    .group_b      (group_b),
    .marker_floor (marker_floor_sample),
    .marker_mark  (marker_mark_sample),
    .queue_full   (queue_full),
    .push         (push),
    .entry        (push_entry)
  );

  lfpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lfpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .left_forward  (left_forward),
    .left_duty     (left_duty),
    .right_forward (right_forward),
    .right_duty    (right_duty),
    .halted        (halted),
    .line_error    (line_error)
  );

endmodule
